### src/gfd_pkg.sv
`default_nettype none
package gfd_pkg;

  localparam int MAX_ROW_LEN  = 1024;
  localparam int ROW_ADDR_W   = $clog2(MAX_ROW_LEN);
  localparam int STORE_DEPTH  = 2 * MAX_ROW_LEN;
  localparam int STORE_ADDR_W = ROW_ADDR_W + 1;
  localparam int LEN_W        = 11;
  localparam int ROWS_W       = 16;
  localparam int COL_W        = 10;
  localparam int RECIP_W      = 48;

  localparam int MQ_DEPTH    = 8;
  localparam int MQ_PTR_W    = $clog2(MQ_DEPTH);
  localparam int OQ_DEPTH    = 16;
  localparam int OQ_PTR_W    = $clog2(OQ_DEPTH);
  localparam int BACK_STAGES = 8;
  localparam int INF_W       = $clog2(BACK_STAGES + 1);

  localparam logic [LEN_W-1:0]   MIN_LEN     = LEN_W'(3);
  localparam logic [LEN_W-1:0]   MAX_LEN     = LEN_W'(MAX_ROW_LEN);
  localparam logic [ROWS_W-1:0]  MIN_ROWS    = ROWS_W'(3);
  localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(1024);
  localparam logic [ROWS_W-1:0]  ROWS_RESET  = ROWS_W'(1024);
  localparam logic [RECIP_W-1:0] RECIP_RESET = 48'h0080_0000_0000;

  typedef enum logic [1:0] {
    REG_ROW_LENGTH = 2'd0,
    REG_ROW_COUNT  = 2'd1,
    REG_RECIP_DX   = 2'd2,
    REG_RECIP_DY   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [31:0] geopotential;
    logic signed [31:0] u_wind;
    logic signed [31:0] v_wind;
    logic [15:0]        map_factor;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0]  tendency;
    logic [COL_W-1:0]    col;
    logic [ROWS_W-1:0]   row;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0]   row_length;
    logic [ROWS_W-1:0]  row_count;
    logic [RECIP_W-1:0] recip_two_dx;
    logic [RECIP_W-1:0] recip_two_dy;
    logic               restart;
  } cfg_t;

  typedef struct packed {
    logic [63:0]        dpu;
    logic [63:0]        dpv;
    logic [15:0]        mf;
    logic [COL_W-1:0]   col;
    logic [ROWS_W-1:0]  row;
  } stencil_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } front_status_t;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROWS_W-1:0] row;
  } back_meta_t;

endpackage
`default_nettype wire

### src/gfd_ram.sv
`default_nettype none
module gfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

### src/gfd_front.sv
`default_nettype none
module gfd_front (
  input  logic                   clk,
  input  logic                   rst,
  input  gfd_pkg::cfg_t          cfg,
  input  logic                   accept,
  input  gfd_pkg::in_word_t      point,
  output gfd_pkg::front_status_t status,
  output logic                   emit_valid,
  output gfd_pkg::stencil_t      emit
);
  import gfd_pkg::*;

  logic [ROW_ADDR_W-1:0] col_pos;
  logic [ROWS_W-1:0]     row_pos;
  logic [LEN_W-1:0]      eff_len;
  logic [ROWS_W-1:0]     eff_rows;
  logic                  col_wrap;
  logic                  row_wrap;

  logic                  s1_valid;
  in_word_t              s1_point;
  logic [ROW_ADDR_W-1:0] s1_col;
  logic                  s1_half;
  logic                  s1_emit;
  logic [COL_W-1:0]      s1_out_col;
  logic [ROWS_W-1:0]     s1_out_row;

  logic                  s2_valid;
  logic [63:0]           s2_pv;
  logic                  s2_emit;
  logic [COL_W-1:0]      s2_out_col;
  logic [ROWS_W-1:0]     s2_out_row;
  logic [63:0]           s2_pu_hi;
  logic [63:0]           s2_pu_lo;
  logic [63:0]           s2_pv_rd;
  logic [15:0]           s2_mf_rd;

  logic signed [63:0]    pu_prod;
  logic signed [63:0]    pv_prod;
  logic [63:0]           pu_hi_rdata;
  logic [63:0]           pu_lo_rdata;
  logic [63:0]           pv_rdata;
  logic [15:0]           mf_rdata;
  logic [STORE_ADDR_W-1:0] hi_addr;
  logic [STORE_ADDR_W-1:0] lo_addr;
  logic [STORE_ADDR_W-1:0] prev_addr;
  logic [STORE_ADDR_W-1:0] base_addr;
  logic [STORE_ADDR_W-1:0] wr_addr;

  always_comb begin
    if (cfg.row_length < MIN_LEN) begin
      eff_len = MIN_LEN;
    end else if (cfg.row_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = cfg.row_length;
    end
    eff_rows = (cfg.row_count < MIN_ROWS) ? MIN_ROWS : cfg.row_count;
  end

  assign col_wrap = (LEN_W'(col_pos) + LEN_W'(1)) >= eff_len;
  assign row_wrap = ((ROWS_W + 1)'(row_pos) + (ROWS_W + 1)'(1)) >= (ROWS_W + 1)'(eff_rows);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (cfg.restart) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_pos <= '0;
        row_pos <= row_wrap ? '0 : row_pos + ROWS_W'(1);
      end else begin
        col_pos <= col_pos + ROW_ADDR_W'(1);
      end
    end
  end

  // row y lives in half y&1; the other half holds row y-1
  assign hi_addr   = {~row_pos[0], col_pos + ROW_ADDR_W'(1)};
  assign lo_addr   = {~row_pos[0], col_pos - ROW_ADDR_W'(1)};
  assign prev_addr = {~row_pos[0], col_pos};
  assign base_addr = {row_pos[0], col_pos};
  assign wr_addr   = {s1_half, s1_col};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
    end
  end

  // the centre is this column one row back
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_point   <= point;
      s1_col     <= col_pos;
      s1_half    <= row_pos[0];
      s1_emit    <= (row_pos >= ROWS_W'(2)) && (col_pos != '0) &&
                    ((LEN_W'(col_pos) + LEN_W'(2)) <= eff_len);
      s1_out_col <= COL_W'(col_pos);
      s1_out_row <= row_pos - ROWS_W'(1);
    end
  end

  assign pu_prod = s1_point.geopotential * s1_point.u_wind;
  assign pv_prod = s1_point.geopotential * s1_point.v_wind;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_pv      <= pv_prod;
      s2_emit    <= s1_emit;
      s2_out_col <= s1_out_col;
      s2_out_row <= s1_out_row;
      s2_pu_hi   <= pu_hi_rdata;
      s2_pu_lo   <= pu_lo_rdata;
      s2_pv_rd   <= pv_rdata;
      s2_mf_rd   <= mf_rdata;
    end
  end

  assign emit_valid = s2_valid && s2_emit;
  assign emit = {s2_pu_hi - s2_pu_lo, s2_pv_rd - s2_pv, s2_mf_rd, s2_out_col, s2_out_row};
  assign status = {s1_valid, s2_valid};

  // the pv store reads row y-2 from the half that this word overwrites in the next cycle
  gfd_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_pu_hi_store (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (wr_addr),
    .wdata (pu_prod),
    .re    (accept),
    .raddr (hi_addr),
    .rdata (pu_hi_rdata)
  );

  gfd_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_pu_lo_store (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (wr_addr),
    .wdata (pu_prod),
    .re    (accept),
    .raddr (lo_addr),
    .rdata (pu_lo_rdata)
  );

  gfd_ram #(.WIDTH(64), .DEPTH(STORE_DEPTH)) u_pv_store (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (wr_addr),
    .wdata (pv_prod),
    .re    (accept),
    .raddr (base_addr),
    .rdata (pv_rdata)
  );

  gfd_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_mf_store (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (wr_addr),
    .wdata (s1_point.map_factor),
    .re    (accept),
    .raddr (prev_addr),
    .rdata (mf_rdata)
  );

  a_restart_home: assert property (@(posedge clk) disable iff (rst)
    cfg.restart |=> (col_pos == '0) && (row_pos == '0))
    else $error("position not cleared on geometry write");

  a_col_in_row: assert property (@(posedge clk) disable iff (rst)
    accept |=> (LEN_W'(col_pos) < eff_len))
    else $error("column position past row end");

  a_emit_interior: assert property (@(posedge clk) disable iff (rst)
    emit_valid |-> (emit.row != '0) && (emit.col != '0))
    else $error("word emitted for an edge point");

endmodule
`default_nettype wire

### src/gfd_back.sv
`default_nettype none
module gfd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [gfd_pkg::RECIP_W-1:0] recip_x,
  input  logic [gfd_pkg::RECIP_W-1:0] recip_y,
  input  logic                        head_valid,
  input  gfd_pkg::stencil_t           head,
  output logic                        take,
  output logic                        empty,
  input  logic                        pop,
  output gfd_pkg::result_t            result
);
  import gfd_pkg::*;

  localparam int CR_W = OQ_PTR_W + 2;
  localparam logic [48:0]  SAT_POS = 49'h0_7FFF_FFFF_FFFF;
  localparam logic [48:0]  SAT_NEG = 49'h0_8000_0000_0000;
  localparam logic [112:0] ROUND52 = 113'(1) << 51;
  localparam logic [96:0]  ROUND24 = 97'(1) << 23;

  logic [BACK_STAGES-1:0] vld;
  logic [INF_W-1:0]       inflight;
  back_meta_t             meta [BACK_STAGES];

  logic [63:0]  b1_magx, b1_magy;
  logic         negx [2:4];
  logic         negy [2:4];
  logic         b1_negx, b1_negy;
  logic [31:0]  m2 [1:6];
  logic [55:0]  b2_x00, b2_x01, b2_x10, b2_x11;
  logic [55:0]  b2_y00, b2_y01, b2_y10, b2_y11;
  logic [80:0]  b3_ax, b3_bx, b3_ay, b3_by;
  logic [112:0] px, py;
  logic [60:0]  b4_tx, b4_ty;
  logic [63:0]  b5_sum;
  logic [63:0]  b6_mag;
  logic         b6_neg, b7_neg, b8_neg;
  logic [63:0]  b7_q0, b7_q1;
  logic [96:0]  tsum;
  logic [72:0]  b8_t;
  logic [47:0]  sat_val;

  result_t              oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]  oq_wr;
  logic [OQ_PTR_W-1:0]  oq_rd;
  logic [OQ_PTR_W:0]    oq_count;
  logic                 oq_push;
  logic                 oq_pop;

  always_comb begin
    inflight = '0;
    for (int i = 0; i < BACK_STAGES; i++) begin
      inflight = inflight + INF_W'(vld[i]);
    end
  end

  // a word enters only if the output queue is sure to have a slot for it
  assign take = head_valid &&
                ((CR_W'(oq_count) + CR_W'(inflight)) < CR_W'(OQ_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[BACK_STAGES-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    meta[0].col <= head.col;
    meta[0].row <= head.row;
    for (int i = 1; i < BACK_STAGES; i++) begin
      meta[i] <= meta[i-1];
    end
  end

  always_ff @(posedge clk) begin
    // magnitudes and m squared
    b1_negx <= head.dpu[63];
    b1_negy <= head.dpv[63];
    b1_magx <= head.dpu[63] ? -head.dpu : head.dpu;
    b1_magy <= head.dpv[63] ? -head.dpv : head.dpv;
    m2[1]   <= head.mf * head.mf;

    // partial products of the reciprocal terms
    b2_x00 <= b1_magx[31:0]  * recip_x[23:0];
    b2_x01 <= b1_magx[31:0]  * recip_x[47:24];
    b2_x10 <= b1_magx[63:32] * recip_x[23:0];
    b2_x11 <= b1_magx[63:32] * recip_x[47:24];
    b2_y00 <= b1_magy[31:0]  * recip_y[23:0];
    b2_y01 <= b1_magy[31:0]  * recip_y[47:24];
    b2_y10 <= b1_magy[63:32] * recip_y[23:0];
    b2_y11 <= b1_magy[63:32] * recip_y[47:24];
    negx[2] <= b1_negx;
    negy[2] <= b1_negy;
    m2[2]   <= m2[1];

    b3_ax <= 81'(b2_x00) + 81'({b2_x01, 24'd0});
    b3_bx <= 81'(b2_x10) + 81'({b2_x11, 24'd0});
    b3_ay <= 81'(b2_y00) + 81'({b2_y01, 24'd0});
    b3_by <= 81'(b2_y10) + 81'({b2_y11, 24'd0});
    negx[3] <= negx[2];
    negy[3] <= negy[2];
    m2[3]   <= m2[2];

    b4_tx   <= px[112:52];
    b4_ty   <= py[112:52];
    negx[4] <= negx[3];
    negy[4] <= negy[3];
    m2[4]   <= m2[3];

    b5_sum  <= (negx[4] ? -{3'd0, b4_tx} : {3'd0, b4_tx}) +
               (negy[4] ? -{3'd0, b4_ty} : {3'd0, b4_ty});
    m2[5]   <= m2[4];

    b6_neg <= b5_sum[63];
    b6_mag <= b5_sum[63] ? -b5_sum : b5_sum;
    m2[6]  <= m2[5];

    b7_q0  <= b6_mag[31:0]  * m2[6];
    b7_q1  <= b6_mag[63:32] * m2[6];
    b7_neg <= b6_neg;

    b8_t   <= tsum[96:24];
    b8_neg <= b7_neg;
  end

  assign px   = 113'(b3_ax) + 113'({b3_bx, 32'd0}) + ROUND52;
  assign py   = 113'(b3_ay) + 113'({b3_by, 32'd0}) + ROUND52;
  assign tsum = 97'(b7_q0) + 97'({b7_q1, 32'd0}) + ROUND24;

  // negative sum gives a positive tendency
  always_comb begin
    if (b8_neg) begin
      sat_val = (b8_t > 73'(SAT_POS)) ? SAT_POS[47:0] : b8_t[47:0];
    end else begin
      sat_val = (b8_t > 73'(SAT_NEG)) ? -SAT_NEG[47:0] : -b8_t[47:0];
    end
  end

  assign oq_push = vld[BACK_STAGES-1];
  assign oq_pop  = pop && !empty;
  assign empty   = (oq_count == '0);
  assign result  = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr].tendency <= sat_val;
      oq[oq_wr].col      <= meta[BACK_STAGES-1].col;
      oq[oq_wr].row      <= meta[BACK_STAGES-1].row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (oq_push) begin
        oq_wr <= oq_wr + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + OQ_PTR_W'(1);
      end
      if (oq_push && !oq_pop) begin
        oq_count <= oq_count + (OQ_PTR_W + 1)'(1);
      end else if (!oq_push && oq_pop) begin
        oq_count <= oq_count - (OQ_PTR_W + 1)'(1);
      end
    end
  end

  a_oq_room: assert property (@(posedge clk) disable iff (rst)
    oq_push |-> (oq_count < (OQ_PTR_W + 1)'(OQ_DEPTH)))
    else $error("output queue written while full");

  a_credit: assert property (@(posedge clk) disable iff (rst)
    (CR_W'(oq_count) + CR_W'(inflight)) <= CR_W'(OQ_DEPTH))
    else $error("back end holds more words than the output queue can take");

  a_take_head: assert property (@(posedge clk) disable iff (rst)
    take |-> head_valid)
    else $error("word taken with nothing at the queue head");

endmodule
`default_nettype wire

### src/geopotential_flux_divergence_stencil.sv
`default_nettype none
// an accepted point goes via s1, s2, the middle queue and the back end to the output queue
// throughput: one point per cycle when not full, set by the line stores (one read and one
//   write a cycle each) and the eight-stage multiply pipeline, both taking a word each cycle
// edge points give no result; the first two rows of a frame give none at all
// reset: position, queue pointers, valid flags and config registers go to their defaults;
//   data registers and line stores are not cleared; points are taken from the first cycle
module geopotential_flux_divergence_stencil (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  gfd_pkg::in_word_t   point,
  output logic                empty,
  input  logic                pop,
  output gfd_pkg::result_t    result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  gfd_pkg::reg_index_t cfg_index,
  input  logic [63:0]         cfg_data
);
  import gfd_pkg::*;

  cfg_t               cfg;
  logic [LEN_W-1:0]   row_length;
  logic [ROWS_W-1:0]  row_count;
  logic [RECIP_W-1:0] recip_two_dx;
  logic [RECIP_W-1:0] recip_two_dy;
  logic               restart;
  front_status_t status;
  logic          accept;
  logic          cfg_write;
  logic          emit_valid;
  stencil_t      emit;
  logic          take;

  stencil_t            mq [MQ_DEPTH];
  logic [MQ_PTR_W-1:0] mq_wr;
  logic [MQ_PTR_W-1:0] mq_rd;
  logic [MQ_PTR_W:0]   mq_count;
  logic [MQ_PTR_W:0]   mq_claimed;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign restart   = cfg_write &&
                     ((cfg_index == REG_ROW_LENGTH) || (cfg_index == REG_ROW_COUNT));
  assign cfg       = {row_length, row_count, recip_two_dx, recip_two_dy, restart};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length   <= LEN_RESET;
      row_count    <= ROWS_RESET;
      recip_two_dx <= RECIP_RESET;
      recip_two_dy <= RECIP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ROW_LENGTH: row_length   <= cfg_data[LEN_W-1:0];
        REG_ROW_COUNT:  row_count    <= cfg_data[ROWS_W-1:0];
        REG_RECIP_DX:   recip_two_dx <= cfg_data[RECIP_W-1:0];
        REG_RECIP_DY:   recip_two_dy <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // words still in the front end each hold a slot in the middle queue
  assign mq_claimed = mq_count + (MQ_PTR_W + 1)'(status.s1_valid)
                               + (MQ_PTR_W + 1)'(status.s2_valid);
  assign full   = (mq_claimed >= (MQ_PTR_W + 1)'(MQ_DEPTH));
  assign accept = push && !full;

  gfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .point      (point),
    .status     (status),
    .emit_valid (emit_valid),
    .emit       (emit)
  );

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      mq[mq_wr] <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mq_wr    <= '0;
      mq_rd    <= '0;
      mq_count <= '0;
    end else begin
      if (emit_valid) begin
        mq_wr <= mq_wr + MQ_PTR_W'(1);
      end
      if (take) begin
        mq_rd <= mq_rd + MQ_PTR_W'(1);
      end
      if (emit_valid && !take) begin
        mq_count <= mq_count + (MQ_PTR_W + 1)'(1);
      end else if (!emit_valid && take) begin
        mq_count <= mq_count - (MQ_PTR_W + 1)'(1);
      end
    end
  end

  gfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .recip_x    (recip_two_dx),
    .recip_y    (recip_two_dy),
    .head_valid (mq_count != '0),
    .head       (mq[mq_rd]),
    .take       (take),
    .empty      (empty),
    .pop        (pop),
    .result     (result)
  );

  a_mq_room: assert property (@(posedge clk) disable iff (rst)
    emit_valid |-> (mq_count < (MQ_PTR_W + 1)'(MQ_DEPTH)))
    else $error("middle queue written while full");

  a_mq_claim: assert property (@(posedge clk) disable iff (rst)
    mq_claimed <= (MQ_PTR_W + 1)'(MQ_DEPTH))
    else $error("more words in flight than middle queue slots");

  a_take_queued: assert property (@(posedge clk) disable iff (rst)
    take |-> (mq_count != '0))
    else $error("back end took a word from an empty middle queue");

endmodule
`default_nettype wire

### verif/tb_geopotential_flux_divergence_stencil.sv
import gfd_pkg::*;

class tendency_board;
  bit [63:0]   pu_store [STORE_DEPTH];
  bit [63:0]   pv_store [STORE_DEPTH];
  bit [15:0]   mf_store [STORE_DEPTH];
  int unsigned x_pos, y_pos;
  bit [10:0]   len_reg;
  bit [15:0]   rows_reg;
  bit [47:0]   rdx, rdy;
  result_t     due_results [$];
  int          errors;

  function new();
    len_reg  = LEN_RESET;
    rows_reg = ROWS_RESET;
    rdx      = RECIP_RESET;
    rdy      = RECIP_RESET;
  endfunction

  function int unsigned grid_len();
    if (len_reg < 3) return 3;
    if (len_reg > MAX_ROW_LEN) return MAX_ROW_LEN;
    return len_reg;
  endfunction

  function int unsigned grid_rows();
    return (rows_reg < 3) ? 3 : rows_reg;
  endfunction

  function void write_reg(reg_index_t idx, bit [63:0] d);
    case (idx)
      REG_ROW_LENGTH: begin
        len_reg = d[10:0];
        x_pos = 0;
        y_pos = 0;
      end
      REG_ROW_COUNT: begin
        rows_reg = d[15:0];
        x_pos = 0;
        y_pos = 0;
      end
      REG_RECIP_DX: rdx = d[47:0];
      REG_RECIP_DY: rdy = d[47:0];
      default: ;
    endcase
  endfunction

  // magnitude product, rounded half up, all ones on overflow
  static function bit [63:0] mul_round(bit [63:0] a, bit [63:0] b, int sh);
    bit [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    p = (p + (128'b1 << (sh - 1))) >> sh;
    if (p[127:64] != 0) return '1;
    return p[63:0];
  endfunction

  static function bit [63:0] scaled(bit [63:0] d, bit [47:0] r);
    bit [63:0] m, t;
    m = d[63] ? -d : d;
    t = mul_round(m, {16'b0, r}, 52);
    return d[63] ? -t : t;
  endfunction

  function void note_point(in_word_t p);
    longint    g, u, v;
    bit [63:0] pu_now, pv_now, sum, mag, t;
    int unsigned b, pr;
    result_t   r;
    g = p.geopotential;
    u = p.u_wind;
    v = p.v_wind;
    pu_now = g * u;
    pv_now = g * v;
    b  = (y_pos & 1) * MAX_ROW_LEN;
    pr = ((y_pos + 1) & 1) * MAX_ROW_LEN;
    if (y_pos >= 2 && x_pos >= 1 && x_pos + 2 <= grid_len()) begin
      sum = scaled(pu_store[pr+x_pos+1] - pu_store[pr+x_pos-1], rdx)
          + scaled(pv_store[b+x_pos] - pv_now, rdy);
      mag = sum[63] ? -sum : sum;
      t = mul_round(mag, {32'b0, mf_store[pr+x_pos]} * {32'b0, mf_store[pr+x_pos]}, 24);
      if (sum[63]) begin
        r.tendency = (t > 64'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF : t[47:0];
      end else begin
        if (t > 64'h8000_0000_0000) t = 64'h8000_0000_0000;
        r.tendency = -t[47:0];
      end
      r.col = x_pos[9:0];
      r.row = 16'(y_pos - 1);
      due_results.push_back(r);
    end
    pu_store[b+x_pos] = pu_now;
    pv_store[b+x_pos] = pv_now;
    mf_store[b+x_pos] = p.map_factor;
    x_pos++;
    if (x_pos >= grid_len()) begin
      x_pos = 0;
      y_pos++;
      if (y_pos >= grid_rows()) y_pos = 0;
    end
  endfunction

  function void check_result(result_t got);
    result_t exp;
    if (due_results.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected word: %h", got);
      return;
    end
    exp = due_results.pop_front();
    if (got.tendency !== exp.tendency || got.col !== exp.col || got.row !== exp.row) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp tend %h col %0d row %0d, got tend %h col %0d row %0d",
                 exp.tendency, exp.col, exp.row, got.tendency, got.col, got.row);
    end
  endfunction
endclass

module tb_geopotential_flux_divergence_stencil;
  logic       clk, rst;
  logic       push, full, empty, pop;
  in_word_t   point;
  result_t    result;
  logic       cfg_valid, cfg_ready;
  reg_index_t cfg_index;
  logic [63:0] cfg_data;

  tendency_board sb = new();
  bit quiet;
  int sent;

  geopotential_flux_divergence_stencil i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .point(point),
    .empty(empty), .pop(pop), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: sample before the edge, accept at the edge
  logic       s_empty, s_pop;
  result_t    s_result;
  always @(negedge clk) begin
    s_empty  = empty;
    s_pop    = pop;
    s_result = result;
  end
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (s_pop && !s_empty) sb.check_result(s_result);
      pop <= quiet || ($urandom_range(99) >= 38);
    end
  end

  function automatic logic [31:0] field32();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      4: return $urandom_range(8191) - 4096;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_word_t any_point();
    in_word_t p;
    p.geopotential = field32();
    p.u_wind       = field32();
    p.v_wind       = field32();
    case ($urandom_range(3))
      0: p.map_factor = 16'hFFFF;
      1: p.map_factor = 16'h1000;
      default: p.map_factor = 16'($urandom);
    endcase
    return p;
  endfunction

  task automatic send_point(in_word_t p);
    logic f;
    while (!quiet && $urandom_range(99) < 38) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push  <= 1'b1;
    point <= p;
    do begin
      @(negedge clk);
      f = full;
      @(posedge clk);
    end while (f);
    sb.note_point(p);
    sent++;
  endtask

  // valid stays high between back-to-back writes; set_grid lowers it
  task automatic write_reg(reg_index_t idx, logic [63:0] d);
    logic r;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
    end while (!r);
    sb.write_reg(idx, d);
  endtask

  // let every expected word drain, then cover words still in flight
  task automatic drain();
    push <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic set_grid(logic [63:0] len, logic [63:0] rows,
                          logic [63:0] rx, logic [63:0] ry);
    write_reg(REG_ROW_LENGTH, len);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_RECIP_DX, rx);
    write_reg(REG_RECIP_DY, ry);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frame(int n);
    repeat (n) send_point(any_point());
  endtask

  initial begin
    in_word_t p;
    int unsigned len, rows, n, phase;
    logic [63:0] lv, rv;
    rst = 1'b1;
    push = 1'b0;
    point = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ROW_LENGTH;
    cfg_data = '0;
    quiet = 1'b0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // default geometry: too few points for any interior word
    run_frame(12);
    drain();

    // smallest grid, full-scale reciprocals, field extremes
    set_grid(64'd3, 64'd3, 64'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF);
    for (int k = 0; k < 9; k++) begin
      p.geopotential = (k % 3 == 0) ? 32'h8000_0000 : (k % 3 == 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
      p.u_wind       = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      p.v_wind       = (k % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
      p.map_factor   = 16'hFFFF;
      send_point(p);
    end
    drain();
    // out-of-range geometry clamps to the minimum, zero reciprocals
    set_grid(64'hFFFF_FFFF_FFFF_F802, 64'd0, 64'd0, 64'd0);
    run_frame(9);
    drain();

    phase = 0;
    while (sent < 1950) begin
      quiet = (phase == 3);
      case ($urandom_range(9))
        0: lv = 64'($urandom_range(2));
        1: lv = 64'(1024 + $urandom_range(1023));
        default: lv = 64'(3 + $urandom_range(9));
      endcase
      if (phase == 1) lv = 64'd100;
      case ($urandom_range(7))
        0: rows = $urandom_range(2);
        1: rows = 65535;
        default: rows = 3 + $urandom_range(4);
      endcase
      if (phase == 1) rows = 3;
      case ($urandom_range(3))
        0: rv = 64'hFFFF_FFFF_FFFF;
        1: rv = 64'd0;
        default: rv = {$urandom, $urandom};
      endcase
      set_grid({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_F800 | lv,
               64'({$urandom, 16'b0} | rows), rv, {$urandom, $urandom});
      len  = sb.grid_len();
      // very long rows only get part of a row to keep the run short
      if (len > 128) begin
        n = 40;
      end else begin
        n = len * ((rows >= 3 && rows <= 8) ? rows + 1 + $urandom_range(rows) : 4);
      end
      run_frame(n);
      drain();
      phase++;
    end
    quiet = 1'b0;
    drain();
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
